// ----- src/loonn_pkg.sv -----
// ----------------------------------------------------------------------------
// loonn_pkg
// Shared types and constants of the leave-one-out nearest-neighbour block.
// ----------------------------------------------------------------------------
package loonn_pkg;

    localparam int CMD_W    = 2;
    localparam int ROW_W    = 10;
    localparam int FEAT_W   = 6;
    localparam int FVAL_W   = 24;
    localparam int CLASS_W  = 8;
    localparam int MASK_W   = 64;
    localparam int CNT_W    = 11;
    localparam int ACC_W    = 14;
    localparam int SCALE    = 10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_FEATURE = 2'd0,
        CMD_WR_CLASS   = 2'd1,
        CMD_EVALUATE   = 2'd2,
        CMD_UNUSED     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ROW_W-1:0]   row_index;
        logic [FEAT_W-1:0]  feature_index;
        logic [FVAL_W-1:0]  feature_value;
        logic [CLASS_W-1:0] class_label;
        logic [MASK_W-1:0]  feature_mask;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] correct_count;
        logic [ACC_W-1:0] accuracy_hundredths;
    } t_out_item;

endpackage

// ----- src/loonn_if.sv -----
// ----------------------------------------------------------------------------
// loonn_in_if / loonn_out_if / loonn_cfg_if
// Valid-ready channels of the block.
// ----------------------------------------------------------------------------
interface loonn_in_if import loonn_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface loonn_out_if import loonn_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface loonn_cfg_if import loonn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/loonn_ram.sv -----
// ----------------------------------------------------------------------------
// loonn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module loonn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/loonn_dist.sv -----
// ----------------------------------------------------------------------------
// loonn_dist
// Shared subtract-square-accumulate unit: one feature pair per cycle, three
// register stages (difference, square, accumulate).
// ----------------------------------------------------------------------------
module loonn_dist import loonn_pkg::*; #(
    parameter int VW    = 24,
    parameter int ACC_B = 60
) (
    input  logic                    i_clk,
    input  logic                    i_clear,
    input  logic                    i_valid,
    input  logic signed [VW-1:0]    i_a,
    input  logic signed [VW-1:0]    i_b,
    output logic [ACC_B-1:0]        o_sum
);
    logic              r_dv;
    logic              r_sv;
    logic [VW:0]       r_abs;
    logic [2*VW+1:0]   r_sq;
    logic [ACC_B-1:0]  r_sum;
    logic signed [VW:0] w_diff;

    assign w_diff = $signed({i_a[VW-1], i_a}) - $signed({i_b[VW-1], i_b});

    // difference, square, accumulate
    always_ff @(posedge i_clk) begin
        r_dv  <= i_valid && !i_clear;
        r_sv  <= r_dv && !i_clear;
        r_abs <= w_diff[VW] ? (VW+1)'(-w_diff) : w_diff;
        r_sq  <= r_abs * r_abs;
        if (i_clear) begin
            r_sum <= '0;
        end else if (r_sv) begin
            r_sum <= r_sum + ACC_B'(r_sq);
        end
    end

    assign o_sum = r_sum;
endmodule

// ----- src/leave_one_out_nn_accuracy.sv -----
// ----------------------------------------------------------------------------
// leave_one_out_nn_accuracy
// Leave-one-out 1-nearest-neighbour classification accuracy.
// ----------------------------------------------------------------------------
// Channels: i_in carries commands (feature write, label write, evaluate),
// o_out carries one result per evaluate, i_cfg writes row_count.
// Load commands are accepted back to back.
// An evaluate walks every ordered row pair (r, o), o != r, over all
// MAX_FEATURES columns through one subtract-square-accumulate unit. The
// single feature RAM read port fetches both operands of a column, so each
// pair passes reads, unit drain and compare; each row adds a label check,
// and the serial percentage division with the result load closes the
// evaluate, which goes straight to the division with fewer than two rows.
// One evaluate runs at a time; the next command is accepted once the block
// is back in idle.
// Reset clears the control state and sets row_count to 1; the stores keep
// their contents and need writing before evaluation.
// The result waits in an output register; while the receiver stalls, loads
// still go through and a following evaluate holds in its last step until
// that register frees.
// ----------------------------------------------------------------------------
module leave_one_out_nn_accuracy import loonn_pkg::*; #(
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_FEATURES = 64,
    parameter int VALUE_WIDTH  = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    loonn_in_if.sink    i_in,
    loonn_cfg_if.sink   i_cfg,
    loonn_out_if.source o_out
);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int AW   = RW + FW;
    localparam int NW   = $clog2(MAX_ROWS + 1);
    localparam int SUMW = 2*VALUE_WIDTH + 2 + FW + 1;
    localparam int QW   = NW + 14;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FEAT  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_CLS   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_row_count;
    logic [NW-1:0]     r_n;
    logic [MASK_W-1:0] r_mask;
    logic [RW-1:0]     r_r, r_o, r_best;
    logic [FW:0]       r_f;
    logic [2:0]        r_drain;
    logic              r_found;
    logic [SUMW-1:0]   r_bdist;
    logic [NW-1:0]     r_correct;
    logic [1:0]        r_cstep;
    logic [CLASS_W-1:0] r_cls_r;
    logic [QW-1:0]     r_num, r_quot;
    logic [NW:0]       r_rem;
    logic [4:0]        r_dcnt;
    t_out_item         r_out;
    logic              r_out_valid;

    // feature store port signals
    logic              w_fwe;
    logic [AW-1:0]     w_fwaddr, w_fraddr;
    logic [VALUE_WIDTH-1:0] w_fdata, r_fa;
    logic              w_cwe;
    logic [RW-1:0]     w_craddr;
    logic [CLASS_W-1:0] w_cdata;
    logic [SUMW-1:0]   w_sum;
    logic              w_acc_valid, w_clear, w_pick;
    logic              w_in_acc, w_last_o, w_last_r;
    logic              w_out_free;
    logic [NW:0]       w_rem_sh;
    logic [FW-1:0]     w_fidx;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_fidx   = r_f[FW-1:0];

    // load writes go straight to the stores
    assign w_fwe    = w_in_acc && i_in.data.cmd == CMD_WR_FEATURE
                      && 32'(i_in.data.row_index) < MAX_ROWS
                      && 32'(i_in.data.feature_index) < MAX_FEATURES;
    assign w_fwaddr = {RW'(i_in.data.row_index), FW'(i_in.data.feature_index)};
    assign w_cwe    = w_in_acc && i_in.data.cmd == CMD_WR_CLASS
                      && 32'(i_in.data.row_index) < MAX_ROWS;

    // one read port: even cycles row r, odd cycles row o, via a phase bit
    logic r_ph;
    assign w_fraddr = {(r_ph ? r_o : r_r), w_fidx};

    loonn_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ROWS*(2**FW))) u_feat (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(w_fwaddr),
        .i_wdata(VALUE_WIDTH'(i_in.data.feature_value)),
        .i_raddr(w_fraddr), .o_rdata(w_fdata)
    );

    assign w_craddr = (r_cstep == 2'd0) ? r_r : r_best;

    loonn_ram #(.WIDTH(CLASS_W), .DEPTH(MAX_ROWS)) u_cls (
        .i_clk(i_clk), .i_we(w_cwe), .i_waddr(RW'(i_in.data.row_index)),
        .i_wdata(i_in.data.class_label), .i_raddr(w_craddr), .o_rdata(w_cdata)
    );

    // masked feature pair enters the unit in the cycle after the o read issues
    logic r_issue, r_issue_m;
    assign w_acc_valid = r_issue;
    assign w_clear     = (r_state == S_IDLE) || (r_state == S_CMP);

    loonn_dist #(.VW(VALUE_WIDTH), .ACC_B(SUMW)) u_dist (
        .i_clk(i_clk), .i_clear(w_clear), .i_valid(w_acc_valid && r_issue_m),
        .i_a(r_fa), .i_b(w_fdata), .o_sum(w_sum)
    );

    assign w_last_o = (NW'(r_o) + NW'(1) == r_n)
                      || ((NW'(r_o) + NW'(2) == r_n) && (r_o + RW'(1) == r_r));
    assign w_last_r = (NW'(r_r) + NW'(1) == r_n);
    assign w_pick   = !r_found || (w_sum < r_bdist);
    assign w_rem_sh = {r_rem[NW-1:0], r_num[QW-1]};
    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in.data.cmd == CMD_EVALUATE) begin
                    n_state = (r_row_count < CNT_W'(2)) ? S_DIV : S_FEAT;
                end
            end
            S_FEAT:  if (r_ph && 32'(r_f) == MAX_FEATURES - 1) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 3'd4) n_state = S_CMP;
            S_CMP:   n_state = w_last_o ? S_CLS : S_FEAT;
            S_CLS:   if (r_cstep == 2'd3) n_state = w_last_r ? S_DIV : S_FEAT;
            S_DIV:   if (r_dcnt == 5'd0) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= CNT_W'(1);
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_row_count <= i_cfg.data;
            end
            // load a finished result, or drop the accepted one
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_issue <= (r_state == S_FEAT) && r_ph;
        end
        r_issue_m <= r_mask[w_fidx] && 32'(r_f) < MAX_FEATURES;
        if (r_state == S_FEAT && !r_ph) begin
            r_fa <= r_fa;
        end
        // capture row r operand in the cycle after its read
        if (r_state == S_FEAT && r_ph) begin
            r_fa <= w_fdata;
        end
        case (r_state)
            S_IDLE: begin
                r_n       <= (32'(r_row_count) > MAX_ROWS) ? NW'(MAX_ROWS)
                                                           : NW'(r_row_count);
                r_mask    <= i_in.data.feature_mask;
                r_r       <= '0;
                r_o       <= RW'(1);
                r_f       <= '0;
                r_ph      <= 1'b0;
                r_found   <= 1'b0;
                r_correct <= (r_row_count == CNT_W'(1)) ? NW'(1) : '0;
                r_cstep   <= '0;
                r_drain   <= '0;
                r_dcnt    <= 5'(QW);
                r_rem     <= '0;
                r_num     <= (r_row_count == CNT_W'(1)) ? QW'(SCALE) : '0;
                r_quot    <= '0;
            end
            S_FEAT: begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    r_f <= r_f + 1'b1;
                end
                r_drain <= '0;
            end
            S_DRAIN: r_drain <= r_drain + 3'd1;
            S_CMP: begin
                if (w_pick) begin
                    r_found <= 1'b1;
                    r_bdist <= w_sum;
                    r_best  <= r_o;
                end
                r_f  <= '0;
                r_ph <= 1'b0;
                r_o  <= (r_o + RW'(1) == r_r) ? r_o + RW'(2) : r_o + RW'(1);
            end
            S_CLS: begin
                r_cstep <= r_cstep + 2'd1;
                if (r_cstep == 2'd1) r_cls_r <= w_cdata;
                if (r_cstep == 2'd3) begin
                    if (w_cdata == r_cls_r) r_correct <= r_correct + 1'b1;
                    r_r     <= r_r + RW'(1);
                    r_o     <= (r_r + RW'(1) == '0) ? RW'(1) : '0;
                    r_found <= 1'b0;
                    r_num   <= QW'(32'(r_correct + ((w_cdata == r_cls_r) ? 1 : 0))
                                   * SCALE);
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (r_dcnt != 5'd0) begin
                    if (r_n != '0 && w_rem_sh >= (NW+1)'(r_n)) begin
                        r_rem  <= w_rem_sh - (NW+1)'(r_n);
                        r_quot <= {r_quot[QW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_quot <= {r_quot[QW-2:0], 1'b0};
                    end
                    r_num  <= {r_num[QW-2:0], 1'b0};
                    r_dcnt <= r_dcnt - 5'd1;
                end
            end
            S_OUT: begin
                // hold here until the result register frees
                if (w_out_free) begin
                    r_out.correct_count       <= CNT_W'(r_correct);
                    r_out.accuracy_hundredths <= (r_n == '0) ? '0 : ACC_W'(r_quot);
                end
            end
            default: ;
        endcase
    end

    // sequencer sanity
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid) else $error("result dropped");
    a_row_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> r_o != r_r) else $error("self pair compared");
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of leave_one_out_nn_accuracy. Preloads the first rows, runs a
// directed set of loads and evaluations, then random traffic over several
// row counts and idling patterns. A scoreboard predicts each evaluation
// result and checks it against what the block returns.
// ----------------------------------------------------------------------------
module tb;
    import loonn_pkg::*;

    localparam int NROWS      = 1024;
    localparam int NFEAT      = 64;
    localparam int LIVE_ROWS  = 8;      // rows kept fully written for evaluation
    localparam int SETTLE     = 100;    // idle cycles before a register write
    localparam longint LIMIT  = 4000000;

    // Accuracy predictor and store of pending results
    class accuracy_board;
        logic signed [FVAL_W-1:0] features [NROWS][NFEAT];
        logic [CLASS_W-1:0]       labels [NROWS];
        logic [CNT_W-1:0]         rows;
        t_out_item                pending [$];
        int                       errors;
        int                       checked;

        function new();
            rows    = 1;
            errors  = 0;
            checked = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function logic [127:0] distance(int a, int b, logic [MASK_W-1:0] mask);
            logic [127:0] sum;
            longint       d;
            sum = 0;
            for (int f = 0; f < NFEAT; f++) begin
                if (mask[f]) begin
                    d   = longint'(features[a][f]) - longint'(features[b][f]);
                    sum = sum + 128'(d * d);
                end
            end
            return sum;
        endfunction

        // Note an accepted transaction: update the stores or predict a result
        function void note_input(t_in_item it);
            t_out_item    res;
            int           n, best, correct;
            logic [127:0] bd, dd;
            bit           found;
            case (it.cmd)
                CMD_WR_FEATURE: features[it.row_index][it.feature_index] = it.feature_value;
                CMD_WR_CLASS:   labels[it.row_index] = it.class_label;
                CMD_EVALUATE: begin
                    n = (rows > NROWS) ? NROWS : rows;
                    correct = 0;
                    for (int r = 0; r < n; r++) begin
                        best  = 0;
                        found = 0;
                        bd    = 0;
                        for (int o = 0; o < n; o++) begin
                            if (o != r) begin
                                dd = distance(r, o, it.feature_mask);
                                if (!found || dd < bd) begin
                                    found = 1;
                                    bd    = dd;
                                    best  = o;
                                end
                            end
                        end
                        if (labels[best] == labels[r])
                            correct++;
                    end
                    res.correct_count       = CNT_W'(correct);
                    res.accuracy_hundredths = (n == 0) ? '0 : ACC_W'(correct * SCALE / n);
                    pending = {pending, res};
                end
                default: ;
            endcase
        endfunction

        // Compare a returned transaction with the oldest prediction
        task check_result(t_out_item got);
            t_out_item exp_res;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result count=%0d acc=%0d",
                                 got.correct_count, got.accuracy_hundredths));
            end else begin
                exp_res = pending.pop_front();
                checked++;
                if (got.correct_count !== exp_res.correct_count)
                    report($sformatf("correct_count got %0d want %0d",
                                     got.correct_count, exp_res.correct_count));
                if (got.accuracy_hundredths !== exp_res.accuracy_hundredths)
                    report($sformatf("accuracy_hundredths got %0d want %0d",
                                     got.accuracy_hundredths, exp_res.accuracy_hundredths));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    loonn_in_if  in_if ();
    loonn_cfg_if cfg_if ();
    loonn_out_if out_if ();

    leave_one_out_nn_accuracy u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    accuracy_board board;
    int            gap_pct;
    int            stall_pct;
    int            items_sent;
    int            evals_sent;
    longint        cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive the receiver's ready with random stalls
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result(out_if.data);
    end

    task send_item(t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data  = it;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_input(it);
        items_sent++;
        if (it.cmd == CMD_EVALUATE)
            evals_sent++;
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    // Hold until all results are back and the block has settled
    task drain();
        while (board.pending.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task write_rows(logic [CNT_W-1:0] value);
        drain();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.rows = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function t_in_item make_item(logic [CMD_W-1:0] cmd, int row, int feat,
                                 logic [FVAL_W-1:0] value, logic [CLASS_W-1:0] label,
                                 logic [MASK_W-1:0] mask);
        t_in_item it;
        it.cmd           = cmd;
        it.row_index     = ROW_W'(row);
        it.feature_index = FEAT_W'(feat);
        it.feature_value = value;
        it.class_label   = label;
        it.feature_mask  = mask;
        return it;
    endfunction

    function t_in_item random_item();
        t_in_item it;
        int       pick;
        it.row_index     = ($urandom_range(9) < 8) ? ROW_W'($urandom_range(LIVE_ROWS - 1))
                                                   : ROW_W'($urandom);
        it.feature_index = FEAT_W'($urandom);
        it.feature_value = ($urandom_range(3) == 0) ? FVAL_W'($urandom_range(15) - 8)
                                                    : FVAL_W'($urandom);
        it.class_label   = ($urandom_range(4) == 0) ? CLASS_W'($urandom)
                                                    : CLASS_W'($urandom_range(2));
        it.feature_mask  = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 50)
            it.cmd = CMD_WR_FEATURE;
        else if (pick < 75)
            it.cmd = CMD_WR_CLASS;
        else if (pick < 95)
            it.cmd = CMD_EVALUATE;
        else
            it.cmd = CMD_UNUSED;
        return it;
    endfunction

    initial begin
        int row_plan [8];
        int phase;

        row_plan     = '{1, 0, 2, 8, 5, 3, 7, 4};
        board        = new();
        gap_pct      = 0;
        stall_pct    = 0;
        items_sent   = 0;
        evals_sent   = 0;
        cycles       = 0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every column and label of the rows that evaluations read
        for (int r = 0; r < LIVE_ROWS; r++) begin
            for (int f = 0; f < NFEAT; f++)
                send_item(make_item(CMD_WR_FEATURE, r, f, FVAL_W'($urandom), '0, '0));
            send_item(make_item(CMD_WR_CLASS, r, 0, '0, CLASS_W'(r % 3), '0));
        end

        // Directed: value extremes, corner addresses, unused command
        send_item(make_item(CMD_WR_FEATURE, 0, 0, 24'h800000, 8'hff, '1));
        send_item(make_item(CMD_WR_FEATURE, 1, 0, 24'h7fffff, 8'h00, '1));
        send_item(make_item(CMD_WR_FEATURE, 1023, 63, 24'hffffff, 8'h00, '1));
        send_item(make_item(CMD_WR_CLASS, 1023, 63, 24'h000000, 8'hff, '1));
        send_item(make_item(CMD_WR_FEATURE, 2, 63, 24'h800000, 8'h00, '0));
        send_item(make_item(CMD_UNUSED, 1023, 63, 24'hffffff, 8'hff, '1));
        // Single row counts as correct; empty mask and full mask
        send_item(make_item(CMD_EVALUATE, 0, 0, '0, '0, '1));
        send_item(make_item(CMD_EVALUATE, 1023, 63, 24'hffffff, 8'hff, '0));
        // Row count above the store depth saturates; write it, then return to zero
        write_rows(11'h7ff);
        write_rows(CNT_W'(0));
        send_item(make_item(CMD_EVALUATE, 0, 0, '0, '0, '1));
        // Ties: rows 3 and 4 copy row 2 in feature 5, so row 2 picks row 3
        write_rows(CNT_W'(LIVE_ROWS));
        send_item(make_item(CMD_WR_FEATURE, 2, 5, 24'h000100, '0, '0));
        send_item(make_item(CMD_WR_FEATURE, 3, 5, 24'h000100, '0, '0));
        send_item(make_item(CMD_WR_FEATURE, 4, 5, 24'h000100, '0, '0));
        send_item(make_item(CMD_WR_CLASS, 3, 0, '0, 8'd7, '0));
        send_item(make_item(CMD_WR_CLASS, 2, 0, '0, 8'd7, '0));
        send_item(make_item(CMD_EVALUATE, 0, 0, '0, '0, 64'h20));
        send_item(make_item(CMD_EVALUATE, 0, 0, '0, '0, 64'h8000_0000_0000_0020));
        send_item(make_item(CMD_EVALUATE, 0, 0, '0, '0, '1));
        write_rows(CNT_W'(2));
        send_item(make_item(CMD_EVALUATE, 0, 0, '0, '0, '1));

        // Hold the sender until every result is back
        drain();

        // Random phases over row counts and idling patterns
        phase = 0;
        while (items_sent < 750) begin
            write_rows(CNT_W'(row_plan[phase % 8]));
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 71; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 71; end
                default: begin gap_pct = 32; stall_pct = 32; end
            endcase
            repeat (40) send_item(random_item());
            phase++;
        end

        gap_pct   = 0;
        stall_pct = 0;
        while (board.pending.size() != 0 && cycles < LIMIT)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Covered %0d transactions, %0d evaluations, %0d results checked",
                 items_sent, evals_sent, board.checked);
        $display("Row counts 0 to %0d, register extreme written, four idling patterns",
                 LIVE_ROWS);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (board.pending.size() != 0)
                $display("%0d results never arrived", board.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
